// ----- hw/rtl/erlp_pkg.sv -----
`timescale 1ns / 1ps

package erlp_pkg;

    // ascii codes used by the line parser
    localparam logic [7:0] CHAR_CR     = 8'd13;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_R      = 8'h52;
    localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TAB    = 8'd9;
    localparam logic [7:0] CHAR_FF     = 8'd12;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // length of the "CR=" prefix
    localparam int PREFIX_LEN = 3;

    // reset value of the discard counter
    localparam logic [7:0] TOSS_RESET = 8'd5;

    // default line buffer size in bytes
    localparam int LINE_BUFFER_BYTES_DEF = 64;

    // magnitude limit of the 64-bit signed accumulator
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

    // number reader phases
    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    // decimal number reader state
    typedef struct packed {
        phase_t      phase;
        logic        negative;
        logic [63:0] accum;
        logic        overflow;
    } num_state_t;

    localparam num_state_t NUM_CLEAR = '{
        phase:    PH_SKIP,
        negative: 1'b0,
        accum:    64'd0,
        overflow: 1'b0
    };

endpackage

// ----- hw/rtl/erlp_num.sv -----
`timescale 1ns / 1ps

// decimal number reader: next state for one byte, and the 32-bit value of
// the current state
module erlp_num (
    input  erlp_pkg::num_state_t cur,
    input  logic [7:0]           data,
    output erlp_pkg::num_state_t fed,
    output logic [31:0]          value
);
    import erlp_pkg::*;

    logic        is_digit;
    logic        is_space;
    logic [3:0]  digit;
    logic [67:0] acc_wide;
    logic [67:0] acc_times10;
    logic [63:0] acc_neg;

    assign is_digit = (data >= CHAR_ZERO) && (data <= CHAR_NINE);
    assign is_space = (data == CHAR_SPACE) || ((data >= CHAR_TAB) && (data <= CHAR_FF));
    assign digit    = data[3:0];

    // accum * 10 + digit as shift and add, overflow when above the limit
    assign acc_wide    = {4'd0, cur.accum};
    assign acc_times10 = (acc_wide << 3) + (acc_wide << 1) + {64'd0, digit};

    // next reader state
    always_comb
    begin
        fed = cur;
        if (cur.phase != PH_DONE)
        begin
            if ((cur.phase == PH_SKIP) && is_space)
            begin
                fed = cur;
            end
            else if ((cur.phase == PH_SKIP) && ((data == CHAR_PLUS) || (data == CHAR_MINUS)))
            begin
                fed.negative = (data == CHAR_MINUS);
                fed.phase    = PH_SIGN;
            end
            else if (!is_digit)
            begin
                fed.phase = PH_DONE;
            end
            else
            begin
                fed.phase = PH_DIGITS;
                if (!cur.overflow)
                begin
                    if (acc_times10 > {4'd0, MAG_LIMIT})
                    begin
                        fed.overflow = 1'b1;
                    end
                    else
                    begin
                        fed.accum = acc_times10[63:0];
                    end
                end
            end
        end
    end

    // saturated result, low 32 bits
    assign acc_neg = 64'd0 - cur.accum;

    always_comb
    begin
        if (cur.overflow || (!cur.negative && (cur.accum == MAG_LIMIT)))
        begin
            value = cur.negative ? 32'd0 : 32'hFFFF_FFFF;
        end
        else if (cur.negative)
        begin
            value = acc_neg[31:0];
        end
        else
        begin
            value = cur.accum[31:0];
        end
    end

endmodule

// ----- hw/rtl/encoder_report_line_parser.sv -----
`timescale 1ns / 1ps

// Encoder report line parser. Bytes of a serial stream enter on in_byte, one
// per transfer, and lines end at carriage return. A kept line of the form
// "CR=<right>:<left>" gives one result (right_count, left_count) when its
// carriage return arrives; both counts are read strtol-style (whitespace,
// sign, digits) with 64-bit saturation, low 32 bits shown. Only the first
// LINE_BUFFER_BYTES-1 bytes of a line are looked at. The first toss_count
// reports (reset 5; a write reloads the counter) are dropped. Throughput is
// one byte per clock while the result register is not stalled; a byte goes
// through an input register and a single update stage into the result
// register. in_ready falls only while the result register is full and not
// taken.
module encoder_report_line_parser #(
    parameter int LINE_BUFFER_BYTES = erlp_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         toss_count,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] right_count,
    output logic signed [31:0] left_count
);
    import erlp_pkg::*;

    localparam int LenW = $clog2(LINE_BUFFER_BYTES);
    localparam logic [LenW-1:0] LenMax = LenW'(LINE_BUFFER_BYTES - 1);

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_advance;

    // line state
    logic [LenW-1:0] line_length_reg, line_length_next;
    logic            prefix_ok_reg, prefix_ok_next;
    logic            colon_seen_reg, colon_seen_next;
    logic [31:0]     first_value_reg, first_value_next;
    logic [7:0]      toss_left_reg, toss_left_next;
    num_state_t      num_reg, num_next;

    // result register
    logic        out_valid_reg;
    logic [31:0] right_reg, left_reg;
    logic        fire;

    num_state_t  num_fed;
    logic [31:0] num_value;

    erlp_num u_num (
        .cur   (num_reg),
        .data  (s1_byte_reg),
        .fed   (num_fed),
        .value (num_value)
    );

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
    end

    // per-byte line update
    always_comb
    begin
        line_length_next = line_length_reg;
        prefix_ok_next   = prefix_ok_reg;
        colon_seen_next  = colon_seen_reg;
        first_value_next = first_value_reg;
        toss_left_next   = toss_left_reg;
        num_next         = num_reg;
        fire             = 1'b0;

        if (s1_byte_reg == CHAR_CR)
        begin
            if (prefix_ok_reg && (line_length_reg > LenW'(PREFIX_LEN)))
            begin
                if (toss_left_reg != 8'd0)
                begin
                    toss_left_next = toss_left_reg - 8'd1;
                end
                else if (colon_seen_reg)
                begin
                    fire = 1'b1;
                end
            end
            line_length_next = '0;
            prefix_ok_next   = 1'b0;
            colon_seen_next  = 1'b0;
            first_value_next = 32'd0;
            num_next         = NUM_CLEAR;
        end
        else if (line_length_reg < LenMax)
        begin
            if (line_length_reg == LenW'(0))
            begin
                prefix_ok_next = (s1_byte_reg == CHAR_C);
            end
            else if (line_length_reg == LenW'(1))
            begin
                prefix_ok_next = prefix_ok_reg && (s1_byte_reg == CHAR_R);
            end
            else if (line_length_reg == LenW'(2))
            begin
                prefix_ok_next = prefix_ok_reg && (s1_byte_reg == CHAR_EQUAL);
            end
            else if (!colon_seen_reg && (s1_byte_reg == CHAR_COLON))
            begin
                colon_seen_next  = 1'b1;
                first_value_next = num_value;
                num_next         = NUM_CLEAR;
            end
            else
            begin
                num_next = num_fed;
            end
            line_length_next = line_length_reg + LenW'(1);
        end
    end

    // line state registers, a configuration write reloads the discard count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= '0;
            prefix_ok_reg   <= 1'b0;
            colon_seen_reg  <= 1'b0;
            first_value_reg <= 32'd0;
            toss_left_reg   <= TOSS_RESET;
            num_reg         <= NUM_CLEAR;
        end
        else
        begin
            if (s1_advance)
            begin
                line_length_reg <= line_length_next;
                prefix_ok_reg   <= prefix_ok_next;
                colon_seen_reg  <= colon_seen_next;
                first_value_reg <= first_value_next;
                num_reg         <= num_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                toss_left_reg <= toss_count;
            end
            else if (s1_advance)
            begin
                toss_left_reg <= toss_left_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= fire;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && fire)
        begin
            right_reg <= first_value_reg;
            left_reg  <= num_value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign right_count = right_reg;
    assign left_count  = left_reg;

endmodule

// ----- hw/rtl/erlp_checker.sv -----
`timescale 1ns / 1ps

// port-level checks for the encoder report line parser
module erlp_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] right_count,
    input logic [31:0] left_count
);

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(right_count) && $stable(left_count))
        else $error("result changed while waiting for transfer");

    // input backpressure only comes from a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

    // the configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

    // no result right out of reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind encoder_report_line_parser erlp_port_checks u_erlp_checker (.*);
